>>> hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int THREAD_COUNT = 8;
  localparam int COUNT_WIDTH  = 16;
  localparam int THREAD_W     = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

  typedef logic [THREAD_W-1:0]     thread_t;
  typedef logic [THREAD_COUNT-1:0] mask_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;

  // largest count, widened to 32 bits for comparison against the request
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  // only thread zero starts enabled
  localparam mask_t DISABLED_RST = ~mask_t'(1);

  localparam thread_t LAST_THREAD = thread_t'(THREAD_COUNT - 1);

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_DELAY   = 3'd1,
    OP_YIELD   = 3'd2,
    OP_CREATE  = 3'd3,
    OP_SUSPEND = 3'd4,
    OP_RESUME  = 3'd5,
    OP_DISABLE = 3'd6,
    OP_ENABLE  = 3'd7
  } opcode_e;

endpackage

`default_nettype wire

>>> hdl/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Eight-thread round-robin scheduler with disable, suspend and tick delay.
// ----------------------------------------------------------------------------
// latency from start transfer to result follows the path: mask ops and creates
//   of a non-running thread go straight to done_o, a tick walks every counter
//   (one counter per cycle) and a reschedule tries one candidate per cycle
// throughput: one command at a time, busy_o stays high through the done_o cycle
// reset: async active low, only thread zero enabled, thread zero running
// the receiver cannot stall: each result shows for one cycle on done_o
`default_nettype none

module round_robin_thread_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [2:0]  thread_num_i,
  input  wire logic [15:0] tick_count_i,
  input  wire logic        start_enabled_i,
  output logic             done_o,
  output logic [2:0]       running_thread_o,
  output logic             ready_found_o,
  output logic             switched_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  rrts_pkg::mask_t   disabled_q, disabled_d;
  rrts_pkg::mask_t   suspended_q, suspended_d;
  rrts_pkg::mask_t   delayed_q, delayed_d;
  rrts_pkg::count_t  counters_q [rrts_pkg::THREAD_COUNT];
  rrts_pkg::thread_t cur_q, cur_d;
  rrts_pkg::thread_t prev_q, prev_d;
  rrts_pkg::thread_t idx_q, idx_d;   // tick walk index and scan candidate
  rrts_pkg::thread_t step_q, step_d; // scan step count
  logic              found_q, found_d;

  // single counter write port
  logic              ctr_we;
  rrts_pkg::thread_t ctr_waddr;
  rrts_pkg::count_t  ctr_wdata;

  rrts_pkg::opcode_e op;
  rrts_pkg::thread_t tn;
  logic              in_range;
  rrts_pkg::mask_t   tn_bit;
  rrts_pkg::mask_t   blocked;
  rrts_pkg::thread_t cand_next;
  rrts_pkg::count_t  ctr_rd;
  rrts_pkg::count_t  delay_cnt;
  logic              accept;

  assign accept   = start_i && (state_q == S_IDLE);
  assign op       = rrts_pkg::opcode_e'(opcode_i);
  assign tn       = rrts_pkg::thread_t'(thread_num_i);
  assign in_range = 32'(thread_num_i) < 32'(rrts_pkg::THREAD_COUNT);
  assign tn_bit   = in_range ? (rrts_pkg::mask_t'(1) << tn) : '0;
  assign blocked  = disabled_q | suspended_q | delayed_q;
  assign cand_next = (idx_q == rrts_pkg::LAST_THREAD) ? '0 : idx_q + rrts_pkg::thread_t'(1);
  assign ctr_rd   = counters_q[idx_q];
  assign delay_cnt = (32'(tick_count_i) > rrts_pkg::COUNT_MAX) ?
                     rrts_pkg::count_t'(rrts_pkg::COUNT_MAX) :
                     rrts_pkg::count_t'(tick_count_i);

  always_comb begin
    state_d     = state_q;
    disabled_d  = disabled_q;
    suspended_d = suspended_q;
    delayed_d   = delayed_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    step_d      = step_q;
    found_d     = found_q;
    ctr_we      = 1'b0;
    ctr_waddr   = idx_q;
    ctr_wdata   = ctr_rd - rrts_pkg::count_t'(1);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          prev_d  = cur_q;
          found_d = 1'b0;
          idx_d   = cur_q;
          step_d  = '0;
          state_d = S_OUT;
          case (op)
            rrts_pkg::OP_TICK: begin
              idx_d   = '0;
              state_d = S_TICK;
            end
            rrts_pkg::OP_DELAY: begin
              ctr_we    = 1'b1;
              ctr_waddr = cur_q;
              ctr_wdata = delay_cnt;
              if (delay_cnt != '0) begin
                delayed_d = delayed_q | (rrts_pkg::mask_t'(1) << cur_q);
              end else begin
                delayed_d = delayed_q & ~(rrts_pkg::mask_t'(1) << cur_q);
              end
              state_d = S_SCAN;
            end
            rrts_pkg::OP_YIELD: begin
              state_d = S_SCAN;
            end
            rrts_pkg::OP_CREATE: begin
              if (in_range) begin
                if (start_enabled_i) begin
                  disabled_d = disabled_q & ~tn_bit;
                end
                if (tn == cur_q) begin
                  state_d = S_SCAN;
                end
              end
            end
            rrts_pkg::OP_SUSPEND: suspended_d = suspended_q | tn_bit;
            rrts_pkg::OP_RESUME:  suspended_d = suspended_q & ~tn_bit;
            rrts_pkg::OP_DISABLE: disabled_d  = disabled_q | tn_bit;
            default:              disabled_d  = disabled_q & ~tn_bit;
          endcase
        end
      end
      S_TICK: begin
        // one counter per cycle through the shared decrementer
        if (ctr_rd != '0) begin
          ctr_we = 1'b1;
          if (ctr_rd == rrts_pkg::count_t'(1)) begin
            delayed_d = delayed_q & ~(rrts_pkg::mask_t'(1) << idx_q);
          end
        end
        idx_d = idx_q + rrts_pkg::thread_t'(1);
        if (idx_q == rrts_pkg::LAST_THREAD) begin
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        // running thread itself is tried last
        idx_d  = cand_next;
        step_d = step_q + rrts_pkg::thread_t'(1);
        if (!blocked[cand_next]) begin
          cur_d   = cand_next;
          found_d = 1'b1;
          state_d = S_OUT;
        end else if (step_q == rrts_pkg::LAST_THREAD) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      disabled_q  <= rrts_pkg::DISABLED_RST;
      suspended_q <= '0;
      delayed_q   <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      for (int i = 0; i < rrts_pkg::THREAD_COUNT; i++) begin
        counters_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      disabled_q  <= disabled_d;
      suspended_q <= suspended_d;
      delayed_q   <= delayed_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      found_q     <= found_d;
      if (ctr_we) begin
        counters_q[ctr_waddr] <= ctr_wdata;
      end
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = (state_q == S_OUT);
  assign running_thread_o = 3'(cur_q);
  assign ready_found_o    = found_q;
  assign switched_o       = (cur_q != prev_q);

endmodule

`default_nettype wire
